### sv/bcomp_pkg.sv
// shared types and constants for the barometric compensation block
`timescale 1ns / 1ps
`default_nettype none

package bcomp_pkg;

    localparam int DATA_W        = 64;
    localparam int ADDR_W        = 5;
    localparam int NUM_W         = 64;
    localparam int DEN_W         = 31;
    localparam int FRONT_STAGES  = 12;
    localparam int POST_STAGES   = 7;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic signed [26:0] TF_OFFSET   = 27'sd128000;
    localparam logic [20:0]        FULL_SCALE  = 21'h100000;
    localparam logic [11:0]        PRESS_SCALE = 12'd3125;
    localparam logic signed [63:0] DIV_BIAS    = 64'sh0000_8000_0000_0000;

    typedef enum logic [1:0] {
        REG_TEMP = 2'd0,
        REG_PLO  = 2'd1,
        REG_PHI  = 2'd2,
        REG_P9   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } coeff_t;

    typedef struct packed {
        logic [23:0]      temp;
        logic [NUM_W-1:0] nmag;
        logic [DEN_W-1:0] dmag;
        logic             qneg;
        logic             dz;
    } div_item_t;

    typedef struct packed {
        logic [23:0] temp;
        logic        qneg;
        logic        dz;
    } side_t;

endpackage

`default_nettype wire

### sv/baro_temp_pressure_compensation.sv
// top level: barometric temperature and pressure compensation
// throughput: one request per cycle while neither side stalls, set by the fully pipelined 64-stage divider
// a stalled result holds the back pipeline; the front keeps accepting until the queue fills
// reset: rst_n asynchronous active low, clears pipeline valids, queue and calibration words
`timescale 1ns / 1ps
`default_nettype none

module baro_temp_pressure_compensation #(
    parameter int QUEUE_DEPTH = bcomp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bcomp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bcomp_pkg::DATA_W-1:0] pwdata,
    output logic      [bcomp_pkg::DATA_W-1:0] prdata,
    output logic                              pready,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [19:0]                  raw_temp,
    input  wire logic [19:0]                  raw_press,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [23:0]                       temp_centideg,
    output logic [31:0]                       press_q24_8,
    output logic                              div_zero
);

    bcomp_pkg::coeff_t    coeff;
    bcomp_pkg::div_item_t f_item;
    bcomp_pkg::div_item_t q_item;
    logic                 f_ready;
    logic                 f_valid;
    logic                 q_full;
    logic                 q_empty;
    logic                 b_take;

    assign full = !f_ready;

    bcomp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coeff   (coeff)
    );

    bcomp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .coeff     (coeff),
        .in_valid  (push && f_ready),
        .raw_temp  (raw_temp),
        .raw_press (raw_press),
        .ready     (f_ready),
        .q_full    (q_full),
        .out_valid (f_valid),
        .out_item  (f_item)
    );

    bcomp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_valid),
        .wdata (f_item),
        .pop   (b_take),
        .rdata (q_item),
        .full  (q_full),
        .empty (q_empty)
    );

    bcomp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .coeff         (coeff),
        .in_valid      (!q_empty),
        .in_item       (q_item),
        .in_take       (b_take),
        .empty         (empty),
        .pop           (pop),
        .temp_centideg (temp_centideg),
        .press_q24_8   (press_q24_8),
        .div_zero      (div_zero)
    );

endmodule

`default_nettype wire

### sv/bcomp_regs.sv
// calibration registers behind the apb configuration port
`timescale 1ns / 1ps
`default_nettype none

module bcomp_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bcomp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bcomp_pkg::DATA_W-1:0] pwdata,
    output logic      [bcomp_pkg::DATA_W-1:0] prdata,
    output logic                              pready,
    output bcomp_pkg::coeff_t                 coeff
);

    logic [47:0] temp_reg;
    logic [63:0] plo_reg;
    logic [63:0] phi_reg;
    logic [15:0] p9_reg;
    logic        wr_en;
    bcomp_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = bcomp_pkg::reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg <= '0;
            plo_reg  <= '0;
            phi_reg  <= '0;
            p9_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                bcomp_pkg::REG_TEMP: temp_reg <= pwdata[47:0];
                bcomp_pkg::REG_PLO:  plo_reg  <= pwdata;
                bcomp_pkg::REG_PHI:  phi_reg  <= pwdata;
                bcomp_pkg::REG_P9:   p9_reg   <= pwdata[15:0];
                default:             p9_reg   <= p9_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            bcomp_pkg::REG_TEMP: prdata = {16'b0, temp_reg};
            bcomp_pkg::REG_PLO:  prdata = plo_reg;
            bcomp_pkg::REG_PHI:  prdata = phi_reg;
            bcomp_pkg::REG_P9:   prdata = {48'b0, p9_reg};
            default:             prdata = '0;
        endcase
    end

    assign coeff.t1 = temp_reg[15:0];
    assign coeff.t2 = temp_reg[31:16];
    assign coeff.t3 = temp_reg[47:32];
    assign coeff.p1 = plo_reg[15:0];
    assign coeff.p2 = plo_reg[31:16];
    assign coeff.p3 = plo_reg[47:32];
    assign coeff.p4 = plo_reg[63:48];
    assign coeff.p5 = phi_reg[15:0];
    assign coeff.p6 = phi_reg[31:16];
    assign coeff.p7 = phi_reg[47:32];
    assign coeff.p8 = phi_reg[63:48];
    assign coeff.p9 = p9_reg;

endmodule

`default_nettype wire

### sv/bcomp_front.sv
// front pipeline: fine temperature, temperature, pressure divisor and numerator
`timescale 1ns / 1ps
`default_nettype none

module bcomp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bcomp_pkg::coeff_t coeff,
    input  wire logic              in_valid,
    input  wire logic [19:0]       raw_temp,
    input  wire logic [19:0]       raw_press,
    output logic                   ready,
    input  wire logic              q_full,
    output logic                   out_valid,
    output bcomp_pkg::div_item_t   out_item
);

    localparam int NS = bcomp_pkg::FRONT_STAGES;

    logic [NS-1:0] vld_reg;
    logic          fe;

    // stage payloads
    logic signed [33:0] s1_m1;
    logic signed [33:0] s1_dd;
    logic [19:0]        s1_rp;
    logic signed [22:0] s2_ta;
    logic signed [38:0] s2_m2;
    logic [19:0]        s2_rp;
    logic signed [25:0] s3_tf;
    logic [19:0]        s3_rp;
    logic [23:0]        s4_temp;
    logic signed [26:0] s4_pa;
    logic [19:0]        s4_rp;
    logic signed [53:0] s5_sq;
    logic signed [42:0] s5_ap5;
    logic signed [42:0] s5_ap2;
    logic [23:0]        s5_temp;
    logic [19:0]        s5_rp;
    logic signed [42:0] s6_h6;
    logic signed [42:0] s6_l6;
    logic signed [42:0] s6_h3;
    logic signed [42:0] s6_l3;
    logic signed [42:0] s6_ap5;
    logic signed [42:0] s6_ap2;
    logic [23:0]        s6_temp;
    logic [19:0]        s6_rp;
    logic signed [63:0] s7_b6;
    logic signed [63:0] s7_c3;
    logic signed [42:0] s7_ap5;
    logic signed [42:0] s7_ap2;
    logic [23:0]        s7_temp;
    logic [19:0]        s7_rp;
    logic signed [63:0] s8_b3;
    logic signed [63:0] s8_s;
    logic [23:0]        s8_temp;
    logic [19:0]        s8_rp;
    logic [63:0]        s9_nm0;
    logic [47:0]        s9_msl;
    logic [31:0]        s9_msh;
    logic [23:0]        s9_temp;
    logic [30:0]        s10_dv;
    logic [43:0]        s10_nlo;
    logic [31:0]        s10_nhi;
    logic [23:0]        s10_temp;
    logic [63:0]        s11_num;
    logic [30:0]        s11_dv;
    logic [23:0]        s11_temp;
    bcomp_pkg::div_item_t s12_item;

    // combinational terms
    logic signed [17:0] x1;
    logic signed [16:0] dt;
    logic signed [28:0] t5;
    logic [20:0]        pp;
    logic [47:0]        msh_full;
    logic [63:0]        prod;
    logic [43:0]        nhi_full;
    logic               nneg;
    logic               dneg;

    assign fe        = !(vld_reg[NS-1] && q_full);
    assign ready     = fe;
    assign out_valid = vld_reg[NS-1] && !q_full;
    assign out_item  = s12_item;

    assign x1 = $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, coeff.t1, 1'b0});
    assign dt = $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, coeff.t1});
    assign t5 = (29'(s3_tf) <<< 2) + 29'(s3_tf) + 29'sd128;
    assign pp = bcomp_pkg::FULL_SCALE - {1'b0, s8_rp};
    assign msh_full = s8_s[63:32] * coeff.p1;
    assign prod     = {16'b0, s9_msl} + {s9_msh, 32'b0};
    assign nhi_full = s9_nm0[63:32] * bcomp_pkg::PRESS_SCALE;
    assign nneg     = s11_num[63];
    assign dneg     = s11_dv[30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (fe)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            s1_m1 <= x1 * $signed(coeff.t2);
            s1_dd <= dt * dt;
            s1_rp <= raw_press;

            s2_ta <= s1_m1[33:11];
            s2_m2 <= $signed({1'b0, s1_dd[33:12]}) * $signed(coeff.t3);
            s2_rp <= s1_rp;

            s3_tf <= 26'(s2_ta) + 26'($signed(s2_m2[38:14]));
            s3_rp <= s2_rp;

            s4_temp <= 24'($signed(t5[28:8]));
            s4_pa   <= 27'(s3_tf) - bcomp_pkg::TF_OFFSET;
            s4_rp   <= s3_rp;

            s5_sq   <= s4_pa * s4_pa;
            s5_ap5  <= 43'(s4_pa * $signed(coeff.p5));
            s5_ap2  <= 43'(s4_pa * $signed(coeff.p2));
            s5_temp <= s4_temp;
            s5_rp   <= s4_rp;

            s6_h6   <= $signed({1'b0, s5_sq[51:26]}) * $signed(coeff.p6);
            s6_l6   <= $signed({1'b0, s5_sq[25:0]}) * $signed(coeff.p6);
            s6_h3   <= $signed({1'b0, s5_sq[51:26]}) * $signed(coeff.p3);
            s6_l3   <= $signed({1'b0, s5_sq[25:0]}) * $signed(coeff.p3);
            s6_ap5  <= s5_ap5;
            s6_ap2  <= s5_ap2;
            s6_temp <= s5_temp;
            s6_rp   <= s5_rp;

            s7_b6   <= (64'(s6_h6) <<< 26) + 64'(s6_l6);
            s7_c3   <= (64'(s6_h3) <<< 26) + 64'(s6_l3);
            s7_ap5  <= s6_ap5;
            s7_ap2  <= s6_ap2;
            s7_temp <= s6_temp;
            s7_rp   <= s6_rp;

            s8_b3   <= s7_b6 + (64'(s7_ap5) <<< 17) + (64'($signed(coeff.p4)) <<< 35);
            s8_s    <= (s7_c3 >>> 8) + (64'(s7_ap2) <<< 12) + bcomp_pkg::DIV_BIAS;
            s8_temp <= s7_temp;
            s8_rp   <= s7_rp;

            s9_nm0  <= ({43'b0, pp} << 31) - s8_b3;
            s9_msl  <= s8_s[31:0] * coeff.p1;
            s9_msh  <= msh_full[31:0];
            s9_temp <= s8_temp;

            s10_dv   <= prod[63:33];
            s10_nlo  <= s9_nm0[31:0] * bcomp_pkg::PRESS_SCALE;
            s10_nhi  <= nhi_full[31:0];
            s10_temp <= s9_temp;

            s11_num  <= {20'b0, s10_nlo} + {s10_nhi, 32'b0};
            s11_dv   <= s10_dv;
            s11_temp <= s10_temp;

            s12_item.temp <= s11_temp;
            s12_item.nmag <= nneg ? (64'd0 - s11_num) : s11_num;
            s12_item.dmag <= dneg ? (31'd0 - s11_dv) : s11_dv;
            s12_item.qneg <= nneg ^ dneg;
            s12_item.dz   <= (s11_dv == 31'd0);
        end
    end

endmodule

`default_nettype wire

### sv/bcomp_fifo.sv
// short request queue between the front and back pipelines
`timescale 1ns / 1ps
`default_nettype none

module bcomp_fifo #(
    parameter int DEPTH = bcomp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire bcomp_pkg::div_item_t wdata,
    input  wire logic                 pop,
    output bcomp_pkg::div_item_t      rdata,
    output logic                      full,
    output logic                      empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    bcomp_pkg::div_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("request pushed into full queue");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push && cnt_reg == 1) |=> empty)
        else $error("queue count out of step with pointers");

endmodule

`default_nettype wire

### sv/bcomp_back.sv
// back pipeline: radix-2 pipelined divider and pressure correction terms
`timescale 1ns / 1ps
`default_nettype none

module bcomp_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bcomp_pkg::coeff_t    coeff,
    input  wire logic                 in_valid,
    input  wire bcomp_pkg::div_item_t in_item,
    output logic                      in_take,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [23:0]               temp_centideg,
    output logic [31:0]               press_q24_8,
    output logic                      div_zero
);

    localparam int NW = bcomp_pkg::NUM_W;
    localparam int DW = bcomp_pkg::DEN_W;
    localparam int NP = bcomp_pkg::POST_STAGES;

    logic ben;

    // divider stages
    logic [NW-1:0]       dvld_reg;
    logic [DW-1:0]       rem_reg [NW];
    logic [NW-1:0]       nq_reg  [NW];
    logic [DW-1:0]       dm_reg  [NW];
    bcomp_pkg::side_t    sb_reg  [NW];
    logic [DW-1:0]       rem_in  [NW];
    logic [NW-1:0]       nq_in   [NW];
    logic [DW-1:0]       dm_in   [NW];
    bcomp_pkg::side_t    sb_in   [NW];
    logic [DW-1:0]       rem_nx  [NW];
    logic [NW-1:0]       nq_nx   [NW];
    logic [DW:0]         trial   [NW];
    logic [NW-1:0]       take;
    bcomp_pkg::side_t    sb_first;

    // correction stages
    logic [NP-1:0]       pvld_reg;
    logic [63:0]         p1_p, p2_p, p3_p, p4_p, p5_p;
    logic [23:0]         p1_temp, p2_temp, p3_temp, p4_temp, p5_temp, p6_temp, p7_temp;
    logic                p1_dz, p2_dz, p3_dz, p4_dz, p5_dz, p6_dz, p7_dz;
    logic [11:0]         p2_hh;
    logic signed [51:0]  p2_hl;
    logic [51:0]         p2_ll;
    logic signed [48:0]  p2_lo8;
    logic [31:0]         p2_hi8;
    logic [63:0]         p3_ss;
    logic [63:0]         p3_pd8;
    logic signed [48:0]  p4_m9lo;
    logic [31:0]         p4_m9hi;
    logic signed [44:0]  p4_d;
    logic [63:0]         p5_bq;
    logic signed [44:0]  p5_d;
    logic [63:0]         p6_sum;
    logic [31:0]         p7_press;

    logic signed [24:0]  sh;
    logic [25:0]         sl;
    logic signed [49:0]  hh_full;
    logic signed [47:0]  hi8_full;
    logic signed [47:0]  m9hi_full;
    logic [63:0]         qd;

    assign ben     = !pvld_reg[NP-1] || pop;
    assign in_take = ben && in_valid;
    assign empty   = !pvld_reg[NP-1];

    assign sb_first.temp = in_item.temp;
    assign sb_first.qneg = in_item.qneg;
    assign sb_first.dz   = in_item.dz;

    always_comb
    begin
        for (int k = 0; k < NW; k++)
        begin
            if (k == 0)
            begin
                rem_in[k] = '0;
                nq_in[k]  = in_item.nmag;
                dm_in[k]  = in_item.dmag;
                sb_in[k]  = sb_first;
            end
            else
            begin
                rem_in[k] = rem_reg[k-1];
                nq_in[k]  = nq_reg[k-1];
                dm_in[k]  = dm_reg[k-1];
                sb_in[k]  = sb_reg[k-1];
            end
            trial[k]  = {rem_in[k], nq_in[k][NW-1]};
            take[k]   = (trial[k] >= {1'b0, dm_in[k]});
            rem_nx[k] = take[k] ? DW'(trial[k] - {1'b0, dm_in[k]}) : trial[k][DW-1:0];
            nq_nx[k]  = {nq_in[k][NW-2:0], take[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg <= '0;
            pvld_reg <= '0;
        end
        else if (ben)
        begin
            dvld_reg <= {dvld_reg[NW-2:0], in_valid};
            pvld_reg <= {pvld_reg[NP-2:0], dvld_reg[NW-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ben)
        begin
            for (int k = 0; k < NW; k++)
            begin
                rem_reg[k] <= rem_nx[k];
                nq_reg[k]  <= nq_nx[k];
                dm_reg[k]  <= dm_in[k];
                sb_reg[k]  <= sb_in[k];
            end
        end
    end

    assign qd        = nq_reg[NW-1];
    assign sh        = $signed(p1_p[63:39]);
    assign sl        = p1_p[38:13];
    assign hh_full   = sh * sh;
    assign hi8_full  = $signed(p1_p[63:32]) * $signed(coeff.p8);
    assign m9hi_full = $signed(p3_ss[63:32]) * $signed(coeff.p9);

    always_ff @(posedge clk)
    begin
        if (ben)
        begin
            p1_p    <= sb_reg[NW-1].qneg ? (64'd0 - qd) : qd;
            p1_temp <= sb_reg[NW-1].temp;
            p1_dz   <= sb_reg[NW-1].dz;

            p2_hh   <= hh_full[11:0];
            p2_hl   <= sh * $signed({1'b0, sl});
            p2_ll   <= sl * sl;
            p2_lo8  <= $signed({1'b0, p1_p[31:0]}) * $signed(coeff.p8);
            p2_hi8  <= hi8_full[31:0];
            p2_p    <= p1_p;
            p2_temp <= p1_temp;
            p2_dz   <= p1_dz;

            p3_ss   <= {12'b0, p2_ll} + (64'(p2_hl) << 27) + {p2_hh, 52'b0};
            p3_pd8  <= 64'(p2_lo8) + {p2_hi8, 32'b0};
            p3_p    <= p2_p;
            p3_temp <= p2_temp;
            p3_dz   <= p2_dz;

            p4_m9lo <= $signed({1'b0, p3_ss[31:0]}) * $signed(coeff.p9);
            p4_m9hi <= m9hi_full[31:0];
            p4_d    <= $signed(p3_pd8[63:19]);
            p4_p    <= p3_p;
            p4_temp <= p3_temp;
            p4_dz   <= p3_dz;

            p5_bq   <= 64'(p4_m9lo) + {p4_m9hi, 32'b0};
            p5_d    <= p4_d;
            p5_p    <= p4_p;
            p5_temp <= p4_temp;
            p5_dz   <= p4_dz;

            p6_sum  <= p5_p + 64'($signed(p5_bq[63:25])) + 64'(p5_d);
            p6_temp <= p5_temp;
            p6_dz   <= p5_dz;

            p7_press <= p6_dz ? 32'd0 : (p6_sum[39:8] + (32'($signed(coeff.p7)) << 4));
            p7_temp  <= p6_temp;
            p7_dz    <= p6_dz;
        end
    end

    assign temp_centideg = p7_temp;
    assign press_q24_8   = p7_press;
    assign div_zero      = p7_dz;

    a_dz_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_item.dz) |-> (in_item.dmag == '0))
        else $error("zero-divisor flag without zero divisor");

    a_dz_press: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && div_zero) |-> (press_q24_8 == 32'd0))
        else $error("pressure not forced to zero on zero divisor");

endmodule

`default_nettype wire

### tb/baro_comp_checker.sv
// checker for the barometric compensation block: predicts each result and compares it
`timescale 1ns / 1ps
`default_nettype none

module baro_comp_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic                         pready,
    input  wire logic [bcomp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bcomp_pkg::DATA_W-1:0] pwdata,
    input  wire logic                         push,
    input  wire logic                         full,
    input  wire logic [19:0]                  raw_temp,
    input  wire logic [19:0]                  raw_press,
    input  wire logic                         empty,
    input  wire logic                         pop,
    input  wire logic [23:0]                  temp_centideg,
    input  wire logic [31:0]                  press_q24_8,
    input  wire logic                         div_zero,
    output int                                fail_count,
    output int                                pending
);

    typedef struct packed {
        logic [23:0] temp;
        logic [31:0] press;
        logic        dz;
    } comp_t;

    logic [47:0] tcoef;
    logic [63:0] plo;
    logic [63:0] phi;
    logic [15:0] p9w;
    comp_t       expected_q[$];

    function automatic longint sx(input logic [15:0] w);
        return longint'($signed(w));
    endfunction

    function automatic comp_t compensate(input logic [19:0] rt_in, input logic [19:0] rp_in);
        longint rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint a, b, d, tf, p, n, t;
        comp_t  r;
        rt = longint'({44'd0, rt_in});
        rp = longint'({44'd0, rp_in});
        t1 = longint'({48'd0, tcoef[15:0]});
        t2 = sx(tcoef[31:16]);
        t3 = sx(tcoef[47:32]);
        p1 = longint'({48'd0, plo[15:0]});
        p2 = sx(plo[31:16]);
        p3 = sx(plo[47:32]);
        p4 = sx(plo[63:48]);
        p5 = sx(phi[15:0]);
        p6 = sx(phi[31:16]);
        p7 = sx(phi[47:32]);
        p8 = sx(phi[63:48]);
        p9 = sx(p9w);

        // fine temperature
        a  = (((rt >>> 3) - (t1 <<< 1)) * t2) >>> 11;
        d  = (rt >>> 4) - t1;
        b  = (((d * d) >>> 12) * t3) >>> 14;
        tf = a + b;
        t  = (tf * 5 + 128) >>> 8;
        if (t > 8388607)
            t = 8388607;
        if (t < -8388608)
            t = -8388608;
        r.temp = t[23:0];

        // pressure
        a = tf - 128000;
        b = a * a * p6;
        b = b + ((a * p5) <<< 17);
        b = b + (p4 <<< 35);
        a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
        a = (((longint'(1) <<< 47) + a) * p1) >>> 33;
        r.press = '0;
        r.dz    = 1'b0;
        if (a == 0)
        begin
            r.dz = 1'b1;
        end
        else
        begin
            p = 1048576 - rp;
            n = ((p <<< 31) - b) * 3125;
            p = (a == -1) ? -n : n / a;
            b = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            d = (p8 * p) >>> 19;
            p = ((p + b + d) >>> 8) + (p7 <<< 4);
            r.press = p[31:0];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        comp_t e;
        int    errs;
        if (!rst_n)
        begin
            tcoef      <= '0;
            plo        <= '0;
            phi        <= '0;
            p9w        <= '0;
            fail_count <= 0;
            pending    <= 0;
            expected_q.delete();
        end
        else
        begin
            errs = 0;
            if (psel && penable && pwrite && pready)
            begin
                case (bcomp_pkg::reg_idx_t'(paddr[4:3]))
                    bcomp_pkg::REG_TEMP: tcoef <= pwdata[47:0];
                    bcomp_pkg::REG_PLO:  plo   <= pwdata;
                    bcomp_pkg::REG_PHI:  phi   <= pwdata;
                    bcomp_pkg::REG_P9:   p9w   <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (push && !full)
                expected_q.push_back(compensate(raw_temp, raw_press));
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errs++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (temp_centideg !== e.temp)
                    begin
                        $error("temp_centideg expected %0h got %0h", e.temp, temp_centideg);
                        errs++;
                    end
                    if (press_q24_8 !== e.press)
                    begin
                        $error("press_q24_8 expected %0h got %0h", e.press, press_q24_8);
                        errs++;
                    end
                    if (div_zero !== e.dz)
                    begin
                        $error("div_zero expected %0b got %0b", e.dz, div_zero);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= expected_q.size();
        end
    end

endmodule

`default_nettype wire

### tb/tb_baro_temp_pressure_compensation.sv
// testbench top for the barometric compensation block: stimulus, register setup and verdict
`timescale 1ns / 1ps
`default_nettype none

module tb_baro_temp_pressure_compensation;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [bcomp_pkg::ADDR_W-1:0]  paddr = '0;
    logic [bcomp_pkg::DATA_W-1:0]  pwdata = '0;
    logic [bcomp_pkg::DATA_W-1:0]  prdata;
    logic                          pready;
    logic                          push = 1'b0;
    logic                          full;
    logic [19:0]                   raw_temp = '0;
    logic [19:0]                   raw_press = '0;
    logic                          empty;
    logic                          pop = 1'b0;
    logic [23:0]                   temp_centideg;
    logic [31:0]                   press_q24_8;
    logic                          div_zero;
    int                            fail_count;
    int                            pending;
    bit                            quiet = 1'b0;

    always #2 clk = ~clk;

    baro_temp_pressure_compensation u_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .raw_temp(raw_temp), .raw_press(raw_press),
        .empty(empty), .pop(pop), .temp_centideg(temp_centideg),
        .press_q24_8(press_q24_8), .div_zero(div_zero)
    );

    baro_comp_checker u_checker (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .pready(pready), .paddr(paddr), .pwdata(pwdata), .push(push), .full(full),
        .raw_temp(raw_temp), .raw_press(raw_press), .empty(empty), .pop(pop),
        .temp_centideg(temp_centideg), .press_q24_8(press_q24_8), .div_zero(div_zero),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int gap_len();
        if (quiet)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return int'($urandom_range(10, 40));
        return ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 3)) : 0;
    endfunction

    task automatic reg_write(input bcomp_pkg::reg_idx_t idx, input logic [63:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_coeffs(input logic [47:0] tc, input logic [63:0] lo,
                              input logic [63:0] hi, input logic [15:0] p9);
        reg_write(bcomp_pkg::REG_TEMP, {16'd0, tc});
        reg_write(bcomp_pkg::REG_PLO, lo);
        reg_write(bcomp_pkg::REG_PHI, hi);
        reg_write(bcomp_pkg::REG_P9, {48'd0, p9});
    endtask

    // one request; push is already aligned to a rising edge
    task automatic send(input logic [19:0] rt, input logic [19:0] rp);
        bit ok;
        int g;
        push      <= 1'b1;
        raw_temp  <= rt;
        raw_press <= rp;
        ok = 1'b0;
        while (!ok)
        begin
            @(negedge clk);
            ok = !full;
            @(posedge clk);
        end
        g = gap_len();
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_random(input int count);
        repeat (count)
        begin
            case ($urandom_range(0, 3))
                0: send(20'($urandom_range(400000, 600000)),
                        20'($urandom_range(250000, 450000)));
                default: send(20'($urandom), 20'($urandom));
            endcase
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // result side stalls
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            pop <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            g = gap_len();
            if (g > 0)
            begin
                pop <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    initial
    begin
        #4ms;
        $display("FAIL baro_temp_pressure_compensation");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients: divisor is zero
        send(20'h00000, 20'h00000);
        send(20'hFFFFF, 20'hFFFFF);
        drain();

        // typical calibration
        set_coeffs({16'hFC18, 16'd26435, 16'd27504},
                   {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                   {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
        send(20'd519888, 20'd415148);
        send(20'h00000, 20'h00000);
        send(20'hFFFFF, 20'hFFFFF);
        send(20'h80000, 20'h7FFFF);
        send(20'h7FFFF, 20'h80000);
        send(20'h00000, 20'hFFFFF);
        send(20'hFFFFF, 20'h00000);
        send(20'h55555, 20'hAAAAA);
        send(20'hAAAAA, 20'h55555);
        send_random(200);
        drain();

        // extremes of the words
        set_coeffs('1, '1, '1, 16'hFFFF);
        send(20'h00000, 20'h00000);
        send(20'hFFFFF, 20'hFFFFF);
        send(20'h12345, 20'hEDCBA);
        drain();
        set_coeffs({16'h8000, 16'h8000, 16'hFFFF}, {{3{16'h8000}}, 16'hFFFF},
                   {4{16'h8000}}, 16'h8000);
        send(20'h00000, 20'hFFFFF);
        send(20'hFFFFF, 20'h00000);
        send_random(20);
        drain();
        set_coeffs({16'h7FFF, 16'h7FFF, 16'h0000}, {{3{16'h7FFF}}, 16'h0001},
                   {4{16'h7FFF}}, 16'h7FFF);
        send(20'h00000, 20'h00000);
        send(20'hFFFFF, 20'hFFFFF);
        send_random(20);
        drain();

        // zero P1 forces the divisor to zero
        set_coeffs({16'hFC18, 16'd26435, 16'd27504}, {16'd2855, 16'd3024, 16'hD643, 16'd0},
                   {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
        send_random(20);
        drain();

        // random calibration sets, some without idling
        for (int ph = 0; ph < 8; ph++)
        begin
            quiet = (ph % 3 == 2);
            set_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom},
                       {$urandom, $urandom}, 16'($urandom));
            send_random(45);
            drain();
        end
        quiet = 1'b0;

        if (fail_count == 0)
            $display("PASS baro_temp_pressure_compensation");
        else
            $display("FAIL baro_temp_pressure_compensation");
        $finish;
    end

endmodule

`default_nettype wire
